// ===== src/pab_pkg.sv =====
// Shared types, widths and the edge product helper for the polygon area block.
`timescale 1ns / 1ps

package pab_pkg;

  localparam int unsigned CoordBits = 16;
  localparam int unsigned ExtBits   = CoordBits + 1;
  localparam int unsigned TermBits  = 2 * CoordBits + 2;
  localparam int unsigned SumBits   = 48;
  localparam int unsigned AreaBits  = 2 * CoordBits + 1;

  typedef logic [CoordBits-1:0]        coord_t;
  typedef logic [ExtBits-1:0]          ext_t;
  typedef logic signed [TermBits-1:0]  term_t;
  typedef logic signed [SumBits-1:0]   sum_t;
  typedef logic [AreaBits-1:0]         area_t;

  // One vertex after the edge stage: both shoelace terms and the box so far
  typedef struct packed {
    logic   first;
    logic   last;
    term_t  edge_term;
    term_t  close_term;
    coord_t min_x;
    coord_t min_y;
    ext_t   width;
    ext_t   height;
  } edge_t;

  // Closed polygon: box, box area and the signed shoelace sum
  typedef struct packed {
    coord_t left;
    coord_t top;
    ext_t   width;
    ext_t   height;
    area_t  area;
    sum_t   sum;
  } box_t;

  // (ax + bx) * (ay - by), exact in TermBits signed bits
  function automatic term_t edge_product(coord_t ax, coord_t bx, coord_t ay, coord_t by);
    ext_t                     s;
    logic signed [ExtBits:0]  s_sgn;
    logic signed [ExtBits-1:0] d;
    s     = {1'b0, ax} + {1'b0, bx};
    s_sgn = {1'b0, s};
    d     = $signed({1'b0, ay}) - $signed({1'b0, by});
    return TermBits'(s_sgn * d);
  endfunction

endpackage

// ===== src/pab_if.sv =====
// Valid/ready channel interfaces for vertices in and polygon results out.
`timescale 1ns / 1ps

interface pab_vertex_if;
  import pab_pkg::*;

  logic   valid;
  logic   ready;
  coord_t vertex_x;
  coord_t vertex_y;
  logic   last_vertex;

  modport source (output valid, vertex_x, vertex_y, last_vertex, input ready);
  modport sink   (input valid, vertex_x, vertex_y, last_vertex, output ready);
endinterface

interface pab_result_if;
  import pab_pkg::*;

  logic   valid;
  logic   ready;
  coord_t box_left;
  coord_t box_top;
  ext_t   box_width;
  ext_t   box_height;
  area_t  box_area;
  area_t  twice_area;

  modport source (output valid, box_left, box_top, box_width, box_height, box_area,
                  twice_area, input ready);
  modport sink   (input valid, box_left, box_top, box_width, box_height, box_area,
                  twice_area, output ready);
endinterface

// ===== src/polygon_area_and_bbox.sv =====
// Top level: polygon bounding box and shoelace area over a vertex stream.
`timescale 1ns / 1ps

// Usage
//   vertex_i carries one polygon vertex per transfer (x, y and a flag on the
//   final vertex). result_o carries one result per polygon: left, top, width
//   and height of the integer bounding box, the box area, and twice the
//   polygon area as the magnitude of the shoelace sum.
//   Throughput: one vertex per cycle while result_o does not stall, through
//   a four-register pipeline (input, edge products, accumulator, result).
//   The last vertex of a polygon passes the input, product, accumulator and
//   result registers to give its result. Vertices that are not last produce
//   no result. The accumulator stage sets the rate: its 48-bit sum closes one
//   vertex per cycle against its own previous value.
//   Reset clears all stage valid bits and the open-polygon flag; the first
//   vertex after reset starts a new polygon.
//   Stall: while result_o waits, the earlier stages keep filling; vertex_i
//   drops ready only once every stage holds an item.
module polygon_area_and_bbox (
  input  logic        clk_i,
  input  logic        rst_ni,
  pab_vertex_if.sink  vertex_i,
  pab_result_if.source result_o
);
  import pab_pkg::*;

  logic  b_valid, b_ready;
  edge_t b_data;
  logic  c_valid, c_ready;
  box_t  c_box;

  pab_edge u_edge (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .vertex_i  (vertex_i),
    .b_valid_o (b_valid),
    .b_data_o  (b_data),
    .b_ready_i (b_ready)
  );

  pab_accum u_accum (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .b_valid_i (b_valid),
    .b_data_i  (b_data),
    .b_ready_o (b_ready),
    .c_valid_o (c_valid),
    .c_box_o   (c_box),
    .c_ready_i (c_ready)
  );

  pab_out u_out (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .c_valid_i (c_valid),
    .c_box_i   (c_box),
    .c_ready_o (c_ready),
    .result_o  (result_o)
  );

endmodule

// ===== src/pab_edge.sv =====
// Input register, per-polygon vertex state, edge products and running extents.
`timescale 1ns / 1ps

module pab_edge (
  input  logic             clk_i,
  input  logic             rst_ni,
  pab_vertex_if.sink       vertex_i,
  output logic             b_valid_o,
  output pab_pkg::edge_t   b_data_o,
  input  logic             b_ready_i
);
  import pab_pkg::*;

  logic   a_valid_q;
  coord_t a_x_q, a_y_q;
  logic   a_last_q;
  logic   a_ready, a_fire;

  logic   in_poly_q;
  coord_t first_x_q, first_y_q, prev_x_q, prev_y_q;
  coord_t min_x_q, max_x_q, min_y_q, max_y_q;
  coord_t min_x_d, max_x_d, min_y_d, max_y_d;
  coord_t fx, fy;
  logic   first;

  logic   b_valid_q;
  edge_t  b_data_q, b_data_d;

  // Stage handshake: a stage moves when the next one is empty or moving
  assign a_ready        = !b_valid_q || b_ready_i;
  assign a_fire         = a_valid_q && a_ready;
  assign vertex_i.ready = !a_valid_q || a_ready;

  // Input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_valid_q <= 1'b0;
    end else if (vertex_i.ready) begin
      a_valid_q <= vertex_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (vertex_i.valid && vertex_i.ready) begin
      a_x_q    <= vertex_i.vertex_x;
      a_y_q    <= vertex_i.vertex_y;
      a_last_q <= vertex_i.last_vertex;
    end
  end

  // First vertex of a polygon stands in for the stored first vertex
  assign first = !in_poly_q;
  assign fx    = first ? a_x_q : first_x_q;
  assign fy    = first ? a_y_q : first_y_q;

  // Running extents including the current vertex
  always_comb begin
    min_x_d = a_x_q;
    max_x_d = a_x_q;
    min_y_d = a_y_q;
    max_y_d = a_y_q;
    if (!first) begin
      if (min_x_q < a_x_q) min_x_d = min_x_q;
      if (max_x_q > a_x_q) max_x_d = max_x_q;
      if (min_y_q < a_y_q) min_y_d = min_y_q;
      if (max_y_q > a_y_q) max_y_d = max_y_q;
    end
  end

  // Shoelace terms: edge from the previous vertex, closing edge on the last one
  always_comb begin
    b_data_d.first      = first;
    b_data_d.last       = a_last_q;
    b_data_d.edge_term  = first ? '0 : edge_product(prev_x_q, a_x_q, prev_y_q, a_y_q);
    b_data_d.close_term = a_last_q ? edge_product(a_x_q, fx, a_y_q, fy) : '0;
    b_data_d.min_x      = min_x_d;
    b_data_d.min_y      = min_y_d;
    b_data_d.width      = {1'b0, max_x_d} - {1'b0, min_x_d} + ExtBits'(1);
    b_data_d.height     = {1'b0, max_y_d} - {1'b0, min_y_d} + ExtBits'(1);
  end

  // Polygon tracking: drop out of the polygon after its last vertex
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_poly_q <= 1'b0;
    end else if (a_fire) begin
      in_poly_q <= !a_last_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      first_x_q <= fx;
      first_y_q <= fy;
      prev_x_q  <= a_x_q;
      prev_y_q  <= a_y_q;
      min_x_q   <= min_x_d;
      max_x_q   <= max_x_d;
      min_y_q   <= min_y_d;
      max_y_q   <= max_y_d;
    end
  end

  // Product register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_valid_q <= 1'b0;
    end else if (a_ready) begin
      b_valid_q <= a_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (a_fire) begin
      b_data_q <= b_data_d;
    end
  end

  assign b_valid_o = b_valid_q;
  assign b_data_o  = b_data_q;

  a_close_clears_poly: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_fire && a_last_q |=> !in_poly_q)
    else $error("polygon still open after its last vertex");

  a_extent_order: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_poly_q |-> (min_x_q <= max_x_q) && (min_y_q <= max_y_q))
    else $error("running extent minimum exceeds maximum");

endmodule

// ===== src/pab_accum.sv =====
// Shoelace accumulator and box area multiplier; passes closed polygons on.
`timescale 1ns / 1ps

module pab_accum (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             b_valid_i,
  input  pab_pkg::edge_t   b_data_i,
  output logic             b_ready_o,
  output logic             c_valid_o,
  output pab_pkg::box_t    c_box_o,
  input  logic             c_ready_i
);
  import pab_pkg::*;

  logic   c_valid_q;
  logic   b_fire;
  sum_t   sum_q, sum_d, sum_base;
  coord_t left_q, top_q;
  ext_t   width_q, height_q;
  area_t  area_q;

  assign b_ready_o = !c_valid_q || c_ready_i;
  assign b_fire    = b_valid_i && b_ready_o;

  // Restart the sum on a polygon's first vertex
  assign sum_base = b_data_i.first ? '0 : sum_q;
  assign sum_d    = sum_base + SumBits'(b_data_i.edge_term) + SumBits'(b_data_i.close_term);

  // Only a closing vertex produces a result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      c_valid_q <= 1'b0;
    end else if (b_ready_o) begin
      c_valid_q <= b_valid_i && b_data_i.last;
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire) begin
      sum_q <= sum_d;
      if (b_data_i.last) begin
        left_q   <= b_data_i.min_x;
        top_q    <= b_data_i.min_y;
        width_q  <= b_data_i.width;
        height_q <= b_data_i.height;
        area_q   <= AreaBits'(b_data_i.width * b_data_i.height);
      end
    end
  end

  assign c_valid_o       = c_valid_q;
  assign c_box_o.left    = left_q;
  assign c_box_o.top     = top_q;
  assign c_box_o.width   = width_q;
  assign c_box_o.height  = height_q;
  assign c_box_o.area    = area_q;
  assign c_box_o.sum     = sum_q;

  a_result_only_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_fire |=> c_valid_q == $past(b_data_i.last))
    else $error("result presence does not follow the last-vertex flag");

  a_sum_held_in_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    c_valid_q && !c_ready_i |=> $stable(sum_q))
    else $error("shoelace sum changed under a waiting result");

endmodule

// ===== src/pab_out.sv =====
// Result register: magnitude of the shoelace sum and the output transfer.
`timescale 1ns / 1ps

module pab_out (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             c_valid_i,
  input  pab_pkg::box_t    c_box_i,
  output logic             c_ready_o,
  pab_result_if.source     result_o
);
  import pab_pkg::*;

  logic   d_valid_q;
  sum_t   mag;
  coord_t left_q, top_q;
  ext_t   width_q, height_q;
  area_t  area_q, twice_q;

  assign c_ready_o = !d_valid_q || result_o.ready;

  // Absolute value of the wrapped sum
  assign mag = c_box_i.sum[SumBits-1] ? -c_box_i.sum : c_box_i.sum;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      d_valid_q <= 1'b0;
    end else if (c_ready_o) begin
      d_valid_q <= c_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (c_valid_i && c_ready_o) begin
      left_q   <= c_box_i.left;
      top_q    <= c_box_i.top;
      width_q  <= c_box_i.width;
      height_q <= c_box_i.height;
      area_q   <= c_box_i.area;
      twice_q  <= mag[AreaBits-1:0];
    end
  end

  assign result_o.valid      = d_valid_q;
  assign result_o.box_left   = left_q;
  assign result_o.box_top    = top_q;
  assign result_o.box_width  = width_q;
  assign result_o.box_height = height_q;
  assign result_o.box_area   = area_q;
  assign result_o.twice_area = twice_q;

  a_area_matches_box: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> area_q == AreaBits'(width_q * height_q))
    else $error("box area does not match width times height");

  a_box_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    d_valid_q |-> (width_q != '0) && (height_q != '0))
    else $error("bounding box has a zero extent");

endmodule

// ===== tb/polygon_area_and_bbox_tb.sv =====
// Self-checking testbench for the polygon bounding box and shoelace area block.
`timescale 1ns / 1ps

module polygon_area_and_bbox_tb;
  import pab_pkg::*;

  localparam int unsigned ClkPeriod     = 8;
  localparam int unsigned ResetCycles   = 12;
  localparam int unsigned MaxGap        = 12;
  localparam int unsigned RandomItems   = 680;
  localparam int unsigned LongLaps      = 25;
  localparam int unsigned StallLimit    = 1000;
  localparam int unsigned DrainCycles   = 10;
  localparam int unsigned MaxErrorLines = 20;

  // How random polygons place their vertices
  typedef enum int unsigned {
    SHAPE_SPREAD,
    SHAPE_CLUSTER,
    SHAPE_CORNER
  } shape_e;

  typedef struct {
    coord_t left;
    coord_t top;
    ext_t   width;
    ext_t   height;
    area_t  box_area;
    area_t  twice_area;
  } polygon_result_t;

  // Tracks the open polygon and queues the box and area it must close with
  class polygon_scoreboard;
    coord_t            first_x, first_y, prev_x, prev_y;
    coord_t            min_x, max_x, min_y, max_y;
    logic [SumBits-1:0] shoelace;
    bit                poly_open;
    int unsigned       poly_len;
    polygon_result_t   expected_boxes[$];
    int unsigned       n_errors, n_vertices, n_checked, longest_poly;

    function new();
      shoelace      = '0;
      poly_open     = 1'b0;
      poly_len      = 0;
      n_errors      = 0;
      n_vertices    = 0;
      n_checked     = 0;
      longest_poly  = 0;
    endfunction

    // (ax + bx) * (ay - by), sign-extended to the accumulator width
    function automatic logic [SumBits-1:0] shoelace_term(coord_t ax, coord_t ay,
                                                         coord_t bx, coord_t by);
      logic signed [SumBits-1:0] s, d;
      s = SumBits'(ax) + SumBits'(bx);
      d = $signed(SumBits'(ay)) - $signed(SumBits'(by));
      return s * d;
    endfunction

    function int unsigned pending();
      return expected_boxes.size();
    endfunction

    task report(string msg);
      n_errors++;
      // print the first few, keep counting the rest
      if (n_errors <= MaxErrorLines) $display("ERROR @%0t: %s", $realtime, msg);
    endtask

    task note_vertex(coord_t x, coord_t y, logic last);
      polygon_result_t      res;
      logic [ExtBits-1:0]   w, h;
      logic [SumBits-1:0]   mag;
      n_vertices++;
      if (!poly_open) begin
        first_x   = x;
        first_y   = y;
        min_x     = x;
        max_x     = x;
        min_y     = y;
        max_y     = y;
        shoelace  = '0;
        poly_open = 1'b1;
        poly_len  = 0;
      end else begin
        shoelace = shoelace + shoelace_term(prev_x, prev_y, x, y);
        if (x < min_x) min_x = x;
        if (x > max_x) max_x = x;
        if (y < min_y) min_y = y;
        if (y > max_y) max_y = y;
      end
      poly_len++;
      prev_x = x;
      prev_y = y;
      if (last) begin
        // close the polygon back to its first vertex
        shoelace = shoelace + shoelace_term(x, y, first_x, first_y);
        w   = ExtBits'(max_x) - ExtBits'(min_x) + 1'b1;
        h   = ExtBits'(max_y) - ExtBits'(min_y) + 1'b1;
        mag = shoelace[SumBits-1] ? (~shoelace + 1'b1) : shoelace;
        res.left       = min_x;
        res.top        = min_y;
        res.width      = w;
        res.height     = h;
        res.box_area   = AreaBits'(w) * AreaBits'(h);
        res.twice_area = mag[AreaBits-1:0];
        expected_boxes.insert(expected_boxes.size(), res);
        if (poly_len > longest_poly) longest_poly = poly_len;
        poly_open = 1'b0;
      end
    endtask

    task check_field(string name, logic [AreaBits-1:0] got, logic [AreaBits-1:0] want);
      if (got !== want)
        report($sformatf("result %0d: %s is 0x%0h, expected 0x%0h", n_checked, name, got,
                         want));
    endtask

    task check_result(polygon_result_t got);
      polygon_result_t want;
      if (expected_boxes.size() == 0) begin
        report("result transfer with no polygon closed");
        return;
      end
      want = expected_boxes.pop_front();
      check_field("box_left", AreaBits'(got.left), AreaBits'(want.left));
      check_field("box_top", AreaBits'(got.top), AreaBits'(want.top));
      check_field("box_width", AreaBits'(got.width), AreaBits'(want.width));
      check_field("box_height", AreaBits'(got.height), AreaBits'(want.height));
      check_field("box_area", got.box_area, want.box_area);
      check_field("twice_area", got.twice_area, want.twice_area);
      n_checked++;
    endtask
  endclass

  logic clk_i;
  logic rst_ni;
  bit   src_no_idle;
  bit   snk_no_idle;
  int unsigned idle_cycles;

  polygon_scoreboard sb;

  pab_vertex_if vertex_bus ();
  pab_result_if result_bus ();

  polygon_area_and_bbox i_dut (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vertex_i (vertex_bus),
    .result_o (result_bus)
  );

  // Free-running clock
  initial begin
    clk_i = 1'b0;
    forever #(ClkPeriod / 2) clk_i = ~clk_i;
  end

  // Transfer one vertex after a random gap; return on the falling edge after it
  task automatic send_vertex(coord_t x, coord_t y, logic last);
    int unsigned gap;
    gap = src_no_idle ? 0 : $urandom_range(0, MaxGap);
    if (gap != 0) begin
      vertex_bus.valid = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    vertex_bus.valid       = 1'b1;
    vertex_bus.vertex_x    = x;
    vertex_bus.vertex_y    = y;
    vertex_bus.last_vertex = last;
    do @(posedge clk_i); while (!vertex_bus.ready);
    @(negedge clk_i);
  endtask

  function automatic coord_t pick_coord(shape_e shape, coord_t base);
    case (shape)
      SHAPE_CLUSTER: begin
        return base + coord_t'($urandom_range(0, 255));
      end
      SHAPE_CORNER: begin
        case ($urandom_range(0, 3))
          0:       return coord_t'(0);
          1:       return coord_t'(1);
          2:       return coord_t'(16'hFFFE);
          default: return coord_t'(16'hFFFF);
        endcase
      end
      default: begin
        return coord_t'($urandom_range(0, 65535));
      end
    endcase
  endfunction

  task automatic send_polygon(int unsigned n_verts, shape_e shape);
    coord_t base_x, base_y;
    base_x = coord_t'($urandom_range(0, 65535 - 255));
    base_y = coord_t'($urandom_range(0, 65535 - 255));
    for (int unsigned k = 0; k < n_verts; k++)
      send_vertex(pick_coord(shape, base_x), pick_coord(shape, base_y), k == n_verts - 1);
  endtask

  // Result side: stall a random number of cycles before each transfer
  initial begin
    int unsigned gap;
    result_bus.ready = 1'b0;
    wait (rst_ni === 1'b1);
    @(negedge clk_i);
    forever begin
      gap = snk_no_idle ? 0 : $urandom_range(0, MaxGap);
      if (gap != 0) begin
        result_bus.ready = 1'b0;
        repeat (gap) @(negedge clk_i);
      end
      result_bus.ready = 1'b1;
      do @(posedge clk_i); while (!result_bus.valid);
      @(negedge clk_i);
    end
  end

  // Monitor both channels and watch for a hung handshake
  always @(posedge clk_i) begin
    polygon_result_t got;
    if (rst_ni) begin
      if (result_bus.valid && result_bus.ready) begin
        got.left       = result_bus.box_left;
        got.top        = result_bus.box_top;
        got.width      = result_bus.box_width;
        got.height     = result_bus.box_height;
        got.box_area   = result_bus.box_area;
        got.twice_area = result_bus.twice_area;
        sb.check_result(got);
      end
      if (vertex_bus.valid && vertex_bus.ready)
        sb.note_vertex(vertex_bus.vertex_x, vertex_bus.vertex_y, vertex_bus.last_vertex);
      if ((vertex_bus.valid && vertex_bus.ready) || (result_bus.valid && result_bus.ready))
        idle_cycles <= 0;
      else if (idle_cycles + 1 >= StallLimit) begin
        $display("Timeout: no transfer for %0d cycles, %0d results outstanding",
                 StallLimit, sb.pending());
        $display("Simulation FAILED");
        $finish;
      end else
        idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus: directed polygons, random polygons, then one long polygon
  initial begin
    int unsigned sent;
    int unsigned n_verts;
    sb                     = new();
    idle_cycles            = 0;
    src_no_idle            = 1'b0;
    snk_no_idle            = 1'b0;
    vertex_bus.valid       = 1'b0;
    vertex_bus.vertex_x    = '0;
    vertex_bus.vertex_y    = '0;
    vertex_bus.last_vertex = 1'b0;
    rst_ni                 = 1'b0;
    repeat (ResetCycles) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // single-vertex polygons at both corners of the coordinate range
    send_vertex(16'h0000, 16'h0000, 1'b1);
    send_vertex(16'hFFFF, 16'hFFFF, 1'b1);
    // full-range triangle
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'hFFFF, 16'h0000, 1'b0);
    send_vertex(16'h0000, 16'hFFFF, 1'b1);
    // full-range square, both windings: largest area and a negative sum
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'hFFFF, 16'h0000, 1'b0);
    send_vertex(16'hFFFF, 16'hFFFF, 1'b0);
    send_vertex(16'h0000, 16'hFFFF, 1'b1);
    send_vertex(16'h0000, 16'h0000, 1'b0);
    send_vertex(16'h0000, 16'hFFFF, 1'b0);
    send_vertex(16'hFFFF, 16'hFFFF, 1'b0);
    send_vertex(16'hFFFF, 16'h0000, 1'b1);
    // degenerate two-vertex polygon
    send_vertex(16'd10, 16'd20, 1'b0);
    send_vertex(16'd30, 16'd5, 1'b1);
    // small triangle
    send_vertex(16'd1, 16'd1, 1'b0);
    send_vertex(16'd4, 16'd1, 1'b0);
    send_vertex(16'd1, 16'd5, 1'b1);
    // alternating bit patterns
    send_vertex(16'hAAAA, 16'h5555, 1'b0);
    send_vertex(16'h5555, 16'hAAAA, 1'b0);
    send_vertex(16'hFFFF, 16'h0000, 1'b1);

    // Random polygons; idling on each side switches per group of polygons
    sent = 0;
    for (int unsigned p = 0; sent < RandomItems; p++) begin
      if (p % 8 == 0) begin
        src_no_idle = ($urandom_range(0, 3) == 0);
        snk_no_idle = ($urandom_range(0, 3) == 0);
      end
      n_verts = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
      send_polygon(n_verts, shape_e'($urandom_range(0, 2)));
      sent += n_verts;
    end

    // Long polygon: each lap subtracts about 2^33, so twice_area overflows 33 bits
    src_no_idle = 1'b1;
    snk_no_idle = 1'b1;
    for (int unsigned lap = 0; lap < LongLaps; lap++) begin
      send_vertex(16'hFFFF, 16'h0000, 1'b0);
      send_vertex(16'hFFFF, 16'hFFFF, 1'b0);
      send_vertex(16'h0000, 16'hFFFF, 1'b0);
      send_vertex(16'h0000, 16'h0000, 1'b0);
    end
    send_vertex(16'h1234, 16'h8765, 1'b1);
    vertex_bus.valid = 1'b0;

    // Drain, then give a stray result time to show up
    src_no_idle = 1'b0;
    snk_no_idle = 1'b0;
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);

    $display("Run covered %0d vertices and checked %0d polygon results.", sb.n_vertices,
             sb.n_checked);
    $display("Longest polygon had %0d vertices; %0d mismatches seen.", sb.longest_poly,
             sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ===== polygon_area_and_bbox.f =====
src/pab_pkg.sv
src/pab_if.sv
src/pab_edge.sv
src/pab_accum.sv
src/pab_out.sv
src/polygon_area_and_bbox.sv
tb/polygon_area_and_bbox_tb.sv
